@@ design/urcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urcm_pkg
// Shared types and constants of the un-premultiply / rounded-corner mask unit.
// ----------------------------------------------------------------------------
package urcm_pkg;

    localparam logic [12:0] DIM_MAX  = 13'd4096;
    localparam logic [4:0]  SUB_ONE  = 5'd16;   // one pixel in 1/16 pixel
    localparam logic [3:0]  SUB_HALF = 4'd8;    // half a pixel in 1/16 pixel
    localparam int unsigned NUM_STAGES = 13;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_CORNER_RADIUS = 2'd2,
        REG_SOURCE_IS_RGBA = 2'd3
    } reg_index_t;

    // Payload carried through every pipeline stage; later stages fill later fields.
    typedef struct packed {
        logic [15:0]       r;
        logic              rzero;
        logic [16:0]       hix;
        logic [16:0]       hiy;
        logic [15:0]       px;
        logic [15:0]       py;
        logic [16:0]       dx;
        logic [16:0]       dy;
        logic              far;
        logic [31:0]       sx;
        logic [31:0]       sy;
        logic [31:0]       s;
        logic [17:0]       rem_s;
        logic [15:0]       root;
        logic [7:0]        a;
        logic [2:0][15:0]  num;
        logic [2:0][7:0]   qrem;
        logic [2:0][7:0]   q;
        logic [2:0]        sat;
        logic [7:0]        ob;
        logic [7:0]        og;
        logic [7:0]        orr;
        logic [7:0]        oa;
    } pipe_t;

endpackage

@@ design/urcm_iter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urcm_iter
// One iteration stage: two digits of the integer square root and one
// quotient bit of each color channel division.
// ----------------------------------------------------------------------------
module urcm_iter
(
    input  urcm_pkg::pipe_t i_stage,
    output urcm_pkg::pipe_t o_stage
);

    logic [19:0] rem;
    logic [19:0] trial;
    logic [8:0]  div9;

    always_comb
    begin
        rem     = '0;
        trial   = '0;
        div9    = '0;
        o_stage = i_stage;
        // square root: bring down two bits, try root*4+1
        for (int k = 0; k < 2; k++)
        begin
            rem   = {o_stage.rem_s, o_stage.s[31:30]};
            trial = {2'b00, o_stage.root, 2'b01};
            o_stage.s = {o_stage.s[29:0], 2'b00};
            if (rem >= trial)
            begin
                o_stage.rem_s = 18'(rem - trial);
                o_stage.root  = {o_stage.root[14:0], 1'b1};
            end
            else
            begin
                o_stage.rem_s = rem[17:0];
                o_stage.root  = {o_stage.root[14:0], 1'b0};
            end
        end
        // restoring division, one quotient bit per channel
        for (int c = 0; c < 3; c++)
        begin
            div9 = {o_stage.qrem[c], o_stage.num[c][7]};
            o_stage.num[c] = {o_stage.num[c][14:0], 1'b0};
            if (div9 >= {1'b0, o_stage.a})
            begin
                o_stage.qrem[c] = 8'(div9 - {1'b0, o_stage.a});
                o_stage.q[c]    = {o_stage.q[c][6:0], 1'b1};
            end
            else
            begin
                o_stage.qrem[c] = div9[7:0];
                o_stage.q[c]    = {o_stage.q[c][6:0], 1'b0};
            end
        end
    end

endmodule

@@ design/unpremultiply_rounded_corner_mask_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unpremultiply_rounded_corner_mask_unit
// Straightens premultiplied pixels and masks alpha with a rounded rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one premultiplied pixel per transaction with its column
//   and row; m_axis returns one BGRA straight-color pixel per transaction,
//   in order. The cfg channel writes frame width, frame height, corner
//   radius (1/16 pixel) and the source byte order; write it only while no
//   pixel is in flight. cfg_ready is always high.
//   One pixel is taken every cycle while s_axis_tready is high: the
//   pipeline has 13 register stages, of which eight each resolve two
//   square-root digits and one quotient bit per color channel.
//   Each stage holds its data only while the stage after it is full and
//   stalled, so bubbles close up and a stalled receiver backs up the
//   pipeline stage by stage; s_axis_tready drops only when all 13 stages
//   are occupied.
//   Reset clears all stage valid bits and sets the registers to 4096 x 4096,
//   radius 0 and BGRA source order.
// ----------------------------------------------------------------------------
module unpremultiply_rounded_corner_mask_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pixel_column[11:0], pixel_row[23:12], first_channel[31:24],
    // second_channel[39:32], third_channel[47:40], alpha_in[55:48]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // blue_out[7:0], green_out[15:8], red_out[23:16], alpha_out[31:24]
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int unsigned NST = urcm_pkg::NUM_STAGES;

    // configuration registers
    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [15:0] corner_radius_reg;
    logic        source_is_rgba_reg;

    logic [NST-1:0]  v_reg;
    logic [NST-1:0]  ld;
    urcm_pkg::pipe_t stg_reg [NST];
    urcm_pkg::pipe_t stg_next [NST];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= urcm_pkg::DIM_MAX;
            frame_height_reg   <= urcm_pkg::DIM_MAX;
            corner_radius_reg  <= '0;
            source_is_rgba_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (urcm_pkg::reg_index_t'(cfg_index))
                urcm_pkg::REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[12:0];
                urcm_pkg::REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[12:0];
                urcm_pkg::REG_CORNER_RADIUS:  corner_radius_reg  <= cfg_data;
                urcm_pkg::REG_SOURCE_IS_RGBA: source_is_rgba_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: clamp the frame, saturate the radius, swap channels and
    // form c*255 for each color channel.
    // ------------------------------------------------------------------
    logic [12:0] w_c;
    logic [12:0] h_c;
    logic [12:0] mn;
    logic [15:0] rmax;
    logic [2:0][7:0] ch;
    logic [7:0]  a_in;

    always_comb
    begin
        w_c = (frame_width_reg == '0) ? 13'd1 :
              (frame_width_reg > urcm_pkg::DIM_MAX) ? urcm_pkg::DIM_MAX : frame_width_reg;
        h_c = (frame_height_reg == '0) ? 13'd1 :
              (frame_height_reg > urcm_pkg::DIM_MAX) ? urcm_pkg::DIM_MAX : frame_height_reg;
        mn   = (w_c < h_c) ? w_c : h_c;
        rmax = {mn[12:0], 3'b000};
        a_in = s_axis_tdata[55:48];
        ch[0] = source_is_rgba_reg ? s_axis_tdata[47:40] : s_axis_tdata[31:24];
        ch[1] = s_axis_tdata[39:32];
        ch[2] = source_is_rgba_reg ? s_axis_tdata[31:24] : s_axis_tdata[47:40];

        stg_next[0]       = '0;
        stg_next[0].r     = (corner_radius_reg > rmax) ? rmax : corner_radius_reg;
        stg_next[0].rzero = (stg_next[0].r == '0);
        stg_next[0].hix   = {w_c, 4'b0000} - {1'b0, stg_next[0].r};
        stg_next[0].hiy   = {h_c, 4'b0000} - {1'b0, stg_next[0].r};
        stg_next[0].px    = {s_axis_tdata[11:0], urcm_pkg::SUB_HALF};
        stg_next[0].py    = {s_axis_tdata[23:12], urcm_pkg::SUB_HALF};
        stg_next[0].a     = a_in;
        for (int c = 0; c < 3; c++)
        begin
            // c >= a saturates; otherwise the quotient fits eight bits
            stg_next[0].sat[c]  = (ch[c] >= a_in);
            stg_next[0].num[c]  = stg_next[0].sat[c] ? 16'd0
                                : ({ch[c], 8'd0} - {8'd0, ch[c]});
            stg_next[0].qrem[c] = stg_next[0].num[c][15:8];
        end
    end

    // Stage 1: offsets from the clamped centre; flag pixels surely outside.
    logic [16:0] r17;
    logic [16:0] px17;
    logic [16:0] py17;
    logic [16:0] lim;

    always_comb
    begin
        r17  = {1'b0, stg_reg[0].r};
        px17 = {1'b0, stg_reg[0].px};
        py17 = {1'b0, stg_reg[0].py};
        lim  = r17 + 17'(urcm_pkg::SUB_HALF);
        stg_next[1] = stg_reg[0];
        if (px17 < r17)
            stg_next[1].dx = r17 - px17;
        else if (px17 > stg_reg[0].hix)
            stg_next[1].dx = px17 - stg_reg[0].hix;
        else
            stg_next[1].dx = '0;
        if (py17 < r17)
            stg_next[1].dy = r17 - py17;
        else if (py17 > stg_reg[0].hiy)
            stg_next[1].dy = py17 - stg_reg[0].hiy;
        else
            stg_next[1].dy = '0;
        // an offset beyond r + half a pixel already drives coverage to zero
        stg_next[1].far = (stg_next[1].dx > lim) || (stg_next[1].dy > lim);
        if (stg_next[1].far)
        begin
            stg_next[1].dx = '0;
            stg_next[1].dy = '0;
        end
    end

    // Stage 2: squares. Stage 3: sum of squares.
    always_comb
    begin
        stg_next[2]    = stg_reg[1];
        stg_next[2].sx = stg_reg[1].dx[15:0] * stg_reg[1].dx[15:0];
        stg_next[2].sy = stg_reg[1].dy[15:0] * stg_reg[1].dy[15:0];
        stg_next[3]    = stg_reg[2];
        stg_next[3].s  = stg_reg[2].sx + stg_reg[2].sy;
    end

    // Stages 4 to 11: square root and division iterations.
    for (genvar g = 4; g < 12; g++)
    begin : g_iter
        urcm_iter u_iter
        (
            .i_stage (stg_reg[g-1]),
            .o_stage (stg_next[g])
        );
    end

    // Stage 12: coverage, alpha scaling and color saturation.
    logic signed [17:0] t_cov;
    logic [4:0]         cov;
    logic [12:0]        prod;

    always_comb
    begin
        t_cov = signed'({2'b00, stg_reg[11].r}) + 18'sd8
              - signed'({2'b00, stg_reg[11].root});
        if (t_cov < 0)
            cov = '0;
        else if (t_cov > 18'sd16)
            cov = urcm_pkg::SUB_ONE;
        else
            cov = t_cov[4:0];
        prod = stg_reg[11].a * cov + 13'(urcm_pkg::SUB_HALF);

        stg_next[12] = stg_reg[11];
        if (stg_reg[11].rzero)
            stg_next[12].oa = stg_reg[11].a;
        else if (stg_reg[11].far)
            stg_next[12].oa = '0;
        else
            stg_next[12].oa = prod[11:4];
        stg_next[12].ob  = (stg_reg[11].a == '0) ? 8'd0 :
                           stg_reg[11].sat[0] ? 8'd255 : stg_reg[11].q[0];
        stg_next[12].og  = (stg_reg[11].a == '0) ? 8'd0 :
                           stg_reg[11].sat[1] ? 8'd255 : stg_reg[11].q[1];
        stg_next[12].orr = (stg_reg[11].a == '0) ? 8'd0 :
                           stg_reg[11].sat[2] ? 8'd255 : stg_reg[11].q[2];
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when empty or when the next one loads.
    // ------------------------------------------------------------------
    always_comb
    begin
        ld[NST-1] = !v_reg[NST-1] || m_axis_tready;
        for (int i = NST - 2; i >= 0; i--)
            ld[i] = !v_reg[i] || ld[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (ld[0])
                v_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NST; i++)
                if (ld[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST; i++)
            if (ld[i])
                stg_reg[i] <= stg_next[i];
    end

    assign s_axis_tready = ld[0];
    assign m_axis_tvalid = v_reg[NST-1];
    assign m_axis_tdata  = {stg_reg[NST-1].oa, stg_reg[NST-1].orr,
                            stg_reg[NST-1].og, stg_reg[NST-1].ob};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&v_reg))
        else $error("input blocked with an empty pipeline stage");

    a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[11] |-> ({2'b00, stg_reg[11].rem_s} <= {3'b000, stg_reg[11].root, 1'b0}))
        else $error("square root remainder exceeds twice the root");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[11] && (stg_reg[11].a != '0) && !stg_reg[11].sat[0])
            |-> (stg_reg[11].qrem[0] < stg_reg[11].a))
        else $error("division remainder not below alpha");

    a_far_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[12] && stg_reg[12].far && !stg_reg[12].rzero) |-> (stg_reg[12].oa == '0))
        else $error("pixel far outside the corner kept alpha");

endmodule
